@@ rtl/gsts_pkg.sv @@
// gsts_pkg: shared types, constants and helpers for the gemm shape tile class sorter
// used by every module of the block and by its checker; depends on nothing else

package gsts_pkg;

   localparam int MAX_RECORDS = 64;
   localparam int DIM_BITS    = 16;
   localparam int CLASS_BITS  = 2;
   localparam int KEY_BITS    = CLASS_BITS + DIM_BITS;
   localparam int ENTRY_BITS  = CLASS_BITS + 3 * DIM_BITS;

   // tile class codes, ordered so that a larger code sorts first
   localparam logic [CLASS_BITS-1:0] CLASS_16 = 2'd0;
   localparam logic [CLASS_BITS-1:0] CLASS_32 = 2'd1;
   localparam logic [CLASS_BITS-1:0] CLASS_64 = 2'd2;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_IDX_BITS  = CSR_ADDR_BITS - 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IDX_SORT_ENABLE = 1'b0;

   typedef struct packed {
      logic [DIM_BITS-1:0] rows_m;
      logic [DIM_BITS-1:0] cols_n;
      logic [DIM_BITS-1:0] depth_k;
      logic                batch_end;
   } req_item_type;

   typedef struct packed {
      logic [DIM_BITS-1:0] out_m;
      logic [DIM_BITS-1:0] out_n;
      logic [DIM_BITS-1:0] out_k;
      logic                out_last;
      logic                overflowed;
   } rsp_item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic load;        // store the accepted item
      logic start_emit;  // batch end accepted, reset the output walk
      logic read;        // read the store at the scan address
      logic emit;        // present the selected record
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_last;   // scan address is the last one of this pass
      logic emit_last;   // the record being emitted ends the batch
   } dp_status_type;

   function automatic logic [CLASS_BITS-1:0] tile_class(
      input logic [DIM_BITS-1:0] m,
      input logic [DIM_BITS-1:0] n
   );
      logic [CLASS_BITS-1:0] cls;
      if (m[5:0] == 6'd0 && n[5:0] == 6'd0) begin
         cls = CLASS_64;
      end else if (m[4:0] == 5'd0 && n[4:0] == 5'd0) begin
         cls = CLASS_32;
      end else begin
         cls = CLASS_16;
      end
      return cls;
   endfunction

endpackage

@@ rtl/gsts_csr.sv @@
// gsts_csr: register port holding the sort enable bit
// depends on gsts_pkg

module gsts_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [gsts_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [gsts_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [gsts_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready,
   output logic                                sort_en
);

   logic sort_en_ff;
   logic sort_en_in;
   logic hit_sort;

   assign hit_sort = (paddr[gsts_pkg::CSR_ADDR_BITS-1:2] == gsts_pkg::CSR_IDX_SORT_ENABLE);

   always_comb begin
      sort_en_in = sort_en_ff;
      if (psel && penable && pwrite && hit_sort) begin
         sort_en_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sort_en_ff <= 1'b1;
      end else begin
         sort_en_ff <= sort_en_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (hit_sort) begin
         prdata[0] = sort_en_ff;
      end
   end

   assign pready  = 1'b1;
   assign sort_en = sort_en_ff;

endmodule

@@ rtl/gsts_ctrl.sv @@
// gsts_ctrl: sequencer for loading records and walking the store on emission
// depends on gsts_pkg

module gsts_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     batch_end,
   input  gsts_pkg::dp_status_type  status,
   output gsts_pkg::ctrl_cmd_type   cmd,
   output logic                     busy,
   output logic                     rsp_valid
);

   gsts_pkg::ctrl_state_type state_ff;
   gsts_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gsts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gsts_pkg::ST_IDLE: begin
            if (start && batch_end) begin
               state_in = gsts_pkg::ST_SCAN;
            end
         end
         gsts_pkg::ST_SCAN: begin
            if (status.scan_last) begin
               state_in = gsts_pkg::ST_DRAIN;
            end
         end
         gsts_pkg::ST_DRAIN: begin
            state_in = gsts_pkg::ST_EMIT;
         end
         gsts_pkg::ST_EMIT: begin
            state_in = status.emit_last ? gsts_pkg::ST_IDLE : gsts_pkg::ST_SCAN;
         end
         default: begin
            state_in = gsts_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         gsts_pkg::ST_IDLE: begin
            busy           = 1'b0;
            cmd.load       = start;
            cmd.start_emit = start && batch_end;
         end
         gsts_pkg::ST_SCAN: begin
            cmd.read = 1'b1;
         end
         gsts_pkg::ST_DRAIN: begin
            // last read of the pass is compared in this cycle
         end
         gsts_pkg::ST_EMIT: begin
            cmd.emit  = 1'b1;
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

@@ rtl/gsts_dp.sv @@
// gsts_dp: record store, scan address, max-key selection and output fields
// depends on gsts_pkg

module gsts_dp #(
   parameter int MAX_RECORDS = gsts_pkg::MAX_RECORDS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  gsts_pkg::ctrl_cmd_type   cmd,
   input  gsts_pkg::req_item_type   req_item,
   input  logic                     sort_en,
   output gsts_pkg::dp_status_type  status,
   output gsts_pkg::rsp_item_type   rsp_item
);

   localparam int ADDR_BITS = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int CNT_BITS  = $clog2(MAX_RECORDS + 1);
   localparam int DB        = gsts_pkg::DIM_BITS;
   localparam int CB        = gsts_pkg::CLASS_BITS;
   localparam int KB        = gsts_pkg::KEY_BITS;
   localparam int EB        = gsts_pkg::ENTRY_BITS;
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(MAX_RECORDS);

   // entry layout: class, m, n, k
   logic [EB-1:0] mem [MAX_RECORDS];

   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 ovf_ff, ovf_in;
   logic [ADDR_BITS-1:0] scan_addr_ff, scan_addr_in;
   logic [ADDR_BITS-1:0] out_idx_ff, out_idx_in;
   logic                 prev_vld_ff, prev_vld_in;
   logic [KB-1:0]        prev_key_ff, prev_key_in;
   logic [ADDR_BITS-1:0] prev_idx_ff, prev_idx_in;
   logic                 rd_vld_ff;
   logic [ADDR_BITS-1:0] rd_idx_ff;
   logic [EB-1:0]        rd_data_ff;
   logic                 best_vld_ff, best_vld_in;
   logic [ADDR_BITS-1:0] best_idx_ff, best_idx_in;
   logic [EB-1:0]        best_data_ff, best_data_in;

   logic                 full;
   logic [ADDR_BITS-1:0] scan_end;
   logic [KB-1:0]        rd_key;
   logic [KB-1:0]        best_key;
   logic                 after_prev;
   logic                 take;
   logic                 emit_last;
   logic [CB-1:0]        wr_class;

   assign full     = (cnt_ff == CNT_FULL);
   assign wr_class = gsts_pkg::tile_class(req_item.rows_m, req_item.cols_n);

   always_ff @(posedge clock) begin
      if (cmd.load && !full) begin
         mem[cnt_ff[ADDR_BITS-1:0]] <= {wr_class, req_item.rows_m, req_item.cols_n,
                                        req_item.depth_k};
      end
      if (cmd.read) begin
         rd_data_ff <= mem[scan_addr_ff];
      end
   end

   // sort key is class then k; equal keys keep arrival order
   assign rd_key   = {rd_data_ff[EB-1 -: CB], rd_data_ff[DB-1:0]};
   assign best_key = {best_data_ff[EB-1 -: CB], best_data_ff[DB-1:0]};

   assign after_prev = !prev_vld_ff || (rd_key < prev_key_ff)
                       || ((rd_key == prev_key_ff) && (rd_idx_ff > prev_idx_ff));
   assign take = rd_vld_ff && (!sort_en || after_prev) && (!best_vld_ff || (rd_key > best_key));

   assign scan_end  = sort_en ? ADDR_BITS'(cnt_ff - CNT_BITS'(1)) : out_idx_ff;
   assign emit_last = ((CNT_BITS'(out_idx_ff) + CNT_BITS'(1)) == cnt_ff);

   always_comb begin
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      scan_addr_in = scan_addr_ff;
      out_idx_in   = out_idx_ff;
      prev_vld_in  = prev_vld_ff;
      prev_key_in  = prev_key_ff;
      prev_idx_in  = prev_idx_ff;
      best_vld_in  = best_vld_ff;
      best_idx_in  = best_idx_ff;
      best_data_in = best_data_ff;

      if (cmd.load) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + CNT_BITS'(1);
         end
      end
      if (cmd.start_emit) begin
         scan_addr_in = '0;
         out_idx_in   = '0;
         prev_vld_in  = 1'b0;
         best_vld_in  = 1'b0;
      end
      if (cmd.read) begin
         scan_addr_in = scan_addr_ff + ADDR_BITS'(1);
      end
      if (take) begin
         best_vld_in  = 1'b1;
         best_idx_in  = rd_idx_ff;
         best_data_in = rd_data_ff;
      end
      if (cmd.emit) begin
         prev_vld_in  = 1'b1;
         prev_key_in  = best_key;
         prev_idx_in  = best_idx_ff;
         best_vld_in  = 1'b0;
         out_idx_in   = out_idx_ff + ADDR_BITS'(1);
         scan_addr_in = sort_en ? '0 : (out_idx_ff + ADDR_BITS'(1));
         if (emit_last) begin
            cnt_in = '0;
            ovf_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         ovf_ff      <= 1'b0;
         rd_vld_ff   <= 1'b0;
         prev_vld_ff <= 1'b0;
         best_vld_ff <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         ovf_ff      <= ovf_in;
         rd_vld_ff   <= cmd.read;
         prev_vld_ff <= prev_vld_in;
         best_vld_ff <= best_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      out_idx_ff   <= out_idx_in;
      prev_key_ff  <= prev_key_in;
      prev_idx_ff  <= prev_idx_in;
      rd_idx_ff    <= scan_addr_ff;
      best_idx_ff  <= best_idx_in;
      best_data_ff <= best_data_in;
   end

   assign status.scan_last = (scan_addr_ff == scan_end);
   assign status.emit_last = emit_last;

   assign rsp_item.out_m      = best_data_ff[3*DB-1 -: DB];
   assign rsp_item.out_n      = best_data_ff[2*DB-1 -: DB];
   assign rsp_item.out_k      = best_data_ff[DB-1:0];
   assign rsp_item.out_last   = emit_last;
   assign rsp_item.overflowed = ovf_ff;

endmodule

@@ rtl/gemm_shape_tile_class_sorter.sv @@
// gemm_shape_tile_class_sorter: collects a batch of (m, n, k) shape records and emits it
// sorted by tile class and k, or in arrival order; uses gsts_pkg, gsts_csr, gsts_ctrl, gsts_dp
//
// usage:
//   an item (req_item) is taken at a rising edge with start high and busy low. each
//   item is written to the store as it is taken; items past MAX_RECORDS are dropped and flag the batch.
//   an item with batch_end set starts emission: busy stays high until the whole batch
//   has gone out on rsp_item, one record per rsp_valid pulse, the last with out_last.
//   results cannot be held off; each one is on the ports for exactly one cycle.
//   with sorting on, each output record takes a full pass over the store (a read of every
//   stored entry, then a final compare and an emit); with sorting off each record is read
//   from its own address, compared and emitted, with no pass over the rest of the store.
//   the store has one write and one registered read port; the pass length sets the rate.
//   the sort_enable register sits at byte address 0 of the apb port (reset value 1); it
//   must be changed only while the block is idle, and the block itself does not enforce this.
//   synchronous reset empties the batch, clears the overflow flag and sets sort_enable;
//   store contents are not cleared, as only entries written in a batch are read.

module gemm_shape_tile_class_sorter #(
   parameter int MAX_RECORDS = gsts_pkg::MAX_RECORDS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  gsts_pkg::req_item_type              req_item,
   output logic                                rsp_valid,
   output gsts_pkg::rsp_item_type              rsp_item,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [gsts_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [gsts_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [gsts_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready
);

   gsts_pkg::ctrl_cmd_type  cmd;
   gsts_pkg::dp_status_type status;
   logic                    sort_en;

   gsts_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .sort_en (sort_en)
   );

   gsts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .batch_end (req_item.batch_end),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   gsts_dp #(
      .MAX_RECORDS (MAX_RECORDS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .sort_en  (sort_en),
      .status   (status),
      .rsp_item (rsp_item)
   );

endmodule

@@ rtl/gsts_checker.sv @@
// gsts_checker: port-level assertions for the sorter, bound to the top level
// depends on gsts_pkg and gemm_shape_tile_class_sorter

module gsts_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input gsts_pkg::req_item_type  req_item,
   input logic                    rsp_valid,
   input gsts_pkg::rsp_item_type  rsp_item
);

   // results only come out while a batch is being emitted
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while not busy");

   // each emitted record is followed by a gap before the next result strobe
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back to back result strobes");

   // the batch-final result returns the block to idle
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.out_last) |=> !busy)
      else $error("busy after last result");

   // an item that ends a batch starts emission
   a_end_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.batch_end) |=> busy)
      else $error("batch end item did not start emission");

endmodule

bind gemm_shape_tile_class_sorter gsts_checker u_gsts_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
